// ===== src/icpr_pkg.sv =====
// shared types and constants for the icmp probe reply classifier
package icpr_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] probe_index;
    } t_out_beat;

    typedef enum logic [1:0] {
        KIND_UNKNOWN  = 2'd0,
        KIND_ECHO     = 2'd1,
        KIND_EXCEEDED = 2'd2,
        KIND_OTHER    = 2'd3
    } t_kind;

    localparam logic [1:0] VERDICT_DROP     = 2'd0;
    localparam logic [1:0] VERDICT_ECHO     = 2'd1;
    localparam logic [1:0] VERDICT_EXCEEDED = 2'd2;

    localparam logic CFG_PROBE_ID     = 1'b0;
    localparam logic CFG_EXPECTED_TTL = 1'b1;

    localparam int          CFG_DATA_W    = 16;
    localparam logic [7:0]  TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0]  TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam int          QUOTE_OFFSET  = 8;

endpackage

// ===== src/icpr_in_stage.sv =====
// input register stage for packet byte beats
module icpr_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  icpr_pkg::t_in_beat i_beat,
    input  logic               i_step,
    output logic               o_valid,
    output icpr_pkg::t_in_beat o_beat
);

    logic               r_valid;
    icpr_pkg::t_in_beat r_beat;

    assign o_ready = !r_valid || i_step;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

// ===== src/icpr_parse.sv =====
// per-packet header walk, id and sequence capture, and verdict logic
module icpr_parse #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  icpr_pkg::t_in_beat  i_beat,
    input  logic [15:0]         i_probe_id,
    input  logic [13:0]         i_expected_ttl,
    output icpr_pkg::t_out_beat o_result
);

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CW = (PW > 8) ? PW : 8;

    logic [PW-1:0]   r_pos, n_pos;
    logic [5:0]      r_icmp_off, n_icmp_off;
    icpr_pkg::t_kind r_kind, n_kind;
    logic [7:0]      r_inner_off, n_inner_off;
    logic [15:0]     r_id, n_id;
    logic [15:0]     r_seq, n_seq;
    logic [3:0]      r_seen, n_seen;
    logic            r_bad, n_bad;

    logic [CW-1:0] w_pos_c, w_icmp_c, w_inner_c, w_rel;
    logic          w_take, w_match;
    logic [3:0]    w_ihl;

    assign w_pos_c   = CW'(r_pos);
    assign w_icmp_c  = CW'(r_icmp_off);
    assign w_inner_c = CW'(r_inner_off);
    assign w_ihl     = i_beat.data_byte[3:0];

    always_comb begin
        n_pos       = r_pos;
        n_icmp_off  = r_icmp_off;
        n_kind      = r_kind;
        n_inner_off = r_inner_off;
        n_id        = r_id;
        n_seq       = r_seq;
        n_seen      = r_seen;
        n_bad       = r_bad;
        w_take      = 1'b0;
        w_rel       = '0;
        if (r_pos >= PW'(MAX_PACKET_BYTES)) begin
            n_bad = 1'b1;
        end else begin
            if (r_pos == '0) begin
                n_icmp_off = {w_ihl, 2'b00};
                if (w_ihl < icpr_pkg::MIN_IHL) begin
                    n_bad = 1'b1;
                end
            end else if (w_pos_c == w_icmp_c) begin
                if (i_beat.data_byte == icpr_pkg::TYPE_ECHO_REPLY) begin
                    n_kind = icpr_pkg::KIND_ECHO;
                end else if (i_beat.data_byte == icpr_pkg::TYPE_TIME_EXCEEDED) begin
                    n_kind = icpr_pkg::KIND_EXCEEDED;
                end else begin
                    n_kind = icpr_pkg::KIND_OTHER;
                end
            end else if (r_kind == icpr_pkg::KIND_ECHO && w_pos_c > w_icmp_c) begin
                w_take = 1'b1;
                w_rel  = w_pos_c - w_icmp_c;
            end else if (r_kind == icpr_pkg::KIND_EXCEEDED && w_pos_c > w_icmp_c) begin
                if (w_pos_c == w_icmp_c + CW'(icpr_pkg::QUOTE_OFFSET)) begin
                    n_inner_off = {2'b00, r_icmp_off} + 8'(icpr_pkg::QUOTE_OFFSET)
                                + {2'b00, w_ihl, 2'b00};
                    if (w_ihl < icpr_pkg::MIN_IHL) begin
                        n_bad = 1'b1;
                    end
                end else if (r_inner_off != '0 && w_pos_c > w_inner_c) begin
                    w_take = 1'b1;
                    w_rel  = w_pos_c - w_inner_c;
                end
            end
            n_pos = r_pos + 1'b1;
        end
        // id and sequence sit at bytes four to seven of the icmp header
        if (w_take && w_rel[CW-1:3] == '0 && w_rel[2]) begin
            case (w_rel[1:0])
                2'd0: begin
                    n_id[7:0] = i_beat.data_byte;
                    n_seen[0] = 1'b1;
                end
                2'd1: begin
                    n_id[15:8] = i_beat.data_byte;
                    n_seen[1]  = 1'b1;
                end
                2'd2: begin
                    n_seq[7:0] = i_beat.data_byte;
                    n_seen[2]  = 1'b1;
                end
                default: begin
                    n_seq[15:8] = i_beat.data_byte;
                    n_seen[3]   = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        w_match = !n_bad && n_seen == 4'hF
               && (n_kind == icpr_pkg::KIND_ECHO || n_kind == icpr_pkg::KIND_EXCEEDED)
               && n_id == i_probe_id && n_seq[15:2] == i_expected_ttl;
        o_result.verdict     = icpr_pkg::VERDICT_DROP;
        o_result.probe_index = 2'd0;
        if (w_match) begin
            o_result.verdict     = (n_kind == icpr_pkg::KIND_ECHO) ? icpr_pkg::VERDICT_ECHO
                                                                   : icpr_pkg::VERDICT_EXCEEDED;
            o_result.probe_index = n_seq[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_icmp_off  <= '0;
            r_kind      <= icpr_pkg::KIND_UNKNOWN;
            r_inner_off <= '0;
            r_seen      <= '0;
            r_bad       <= 1'b0;
        end else if (i_step) begin
            if (i_beat.last_byte) begin
                r_pos       <= '0;
                r_icmp_off  <= '0;
                r_kind      <= icpr_pkg::KIND_UNKNOWN;
                r_inner_off <= '0;
                r_seen      <= '0;
                r_bad       <= 1'b0;
            end else begin
                r_pos       <= n_pos;
                r_icmp_off  <= n_icmp_off;
                r_kind      <= n_kind;
                r_inner_off <= n_inner_off;
                r_seen      <= n_seen;
                r_bad       <= n_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_id  <= n_id;
            r_seq <= n_seq;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_beat.last_byte |=> r_pos == '0 && r_seen == '0 && !r_bad)
        else $error("packet state not cleared after last beat");

endmodule

// ===== src/icpr_out_stage.sv =====
// result register for verdict beats
module icpr_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  icpr_pkg::t_out_beat i_result,
    input  logic                i_ready,
    output logic                o_free,
    output logic                o_valid,
    output icpr_pkg::t_out_beat o_beat
);

    logic                r_valid;
    icpr_pkg::t_out_beat r_beat;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_beat <= i_result;
        end
    end

endmodule

// ===== src/icmp_probe_reply_classifier_unit.sv =====
// top level of the icmp probe reply classifier
// Takes a received IPv4 packet one byte per beat, starting at the IP header, and
// on the beat marked last delivers one verdict beat: drop, matching echo reply or
// matching time exceeded, with the probe index from the low two sequence bits.
// One byte is accepted every cycle; a byte passes an input register, is parsed
// combinationally against the packet state, and a last byte's verdict lands in
// the result register. Only a last byte waits, and only while the result
// register holds an untaken verdict. probe_id and expected_ttl are written
// through the config port; the user must do that between packets (not enforced).
module icmp_probe_reply_classifier_unit #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  icpr_pkg::t_in_beat                  i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output icpr_pkg::t_out_beat                 o_out_beat,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [icpr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [15:0]         r_probe_id;
    logic [13:0]         r_expected_ttl;
    logic                w_in_valid;
    logic                w_out_free;
    logic                w_step;
    icpr_pkg::t_in_beat  w_in_beat;
    icpr_pkg::t_out_beat w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_id     <= 16'd0;
            r_expected_ttl <= 14'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                icpr_pkg::CFG_PROBE_ID:     r_probe_id     <= i_cfg_data[15:0];
                icpr_pkg::CFG_EXPECTED_TTL: r_expected_ttl <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    assign w_step = w_in_valid && (!w_in_beat.last_byte || w_out_free);

    icpr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (i_in_beat),
        .i_step  (w_step),
        .o_valid (w_in_valid),
        .o_beat  (w_in_beat)
    );

    icpr_parse #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_beat         (w_in_beat),
        .i_probe_id     (r_probe_id),
        .i_expected_ttl (r_expected_ttl),
        .o_result       (w_result)
    );

    icpr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step && w_in_beat.last_byte),
        .i_result (w_result),
        .i_ready  (i_out_ready),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .o_beat   (o_out_beat)
    );

    a_verdict_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_in_beat.last_byte |=> o_out_valid)
        else $error("last beat parsed without a verdict beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_in_beat.last_byte |-> !o_out_valid || i_out_ready)
        else $error("verdict would overwrite an untaken beat");

    a_drop_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.verdict == icpr_pkg::VERDICT_DROP
            |-> o_out_beat.probe_index == 2'd0)
        else $error("dropped packet carries a probe index");

endmodule
